/* sv/hmim_pkg.sv */
// Shared constants, codes and types of the hierarchy module index mapper.
`timescale 1ns / 1ps

package hmim_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int VALUE_WIDTH = 33;
    localparam int SIZE_W      = 8;
    localparam int LCNT_W      = 3;
    localparam int LAYER_W     = 2;
    localparam int TGT_W       = 3;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int PROD2_W     = 2 * SIZE_W;
    localparam int DIV_W       = SIZE_W * (MAX_LAYERS - 1);
    localparam int K_W         = SIZE_W * MAX_LAYERS;
    localparam int END_W       = VALUE_WIDTH + 1;
    localparam int DIV_LAST    = VALUE_WIDTH - 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W   = ((VALUE_WIDTH + LAYER_W + TGT_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VALUE_WIDTH + LAYER_W + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_BLOCK_TO_MODULE = 2'd0;
    localparam logic [OP_W-1:0] OP_CONVERT         = 2'd1;
    localparam logic [OP_W-1:0] OP_MODULE_TO_FLAT  = 2'd2;
    localparam logic [OP_W-1:0] OP_FLAT_TO_MODULE  = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_LAYER_RANGE  = 2'd1;
    localparam logic [ST_W-1:0] ST_PAST_LAST    = 2'd2;
    localparam logic [ST_W-1:0] ST_TARGET_BELOW = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_3      = 3'd4;

    // derived layout: spans are products of sizes from layer lo up to hi-1,
    // ends[l] is one past the last flat id of layer l
    typedef struct packed {
        logic [LCNT_W-1:0]                  used_layers;
        logic [DIV_W-1:0]                   span_01;
        logic [DIV_W-1:0]                   span_02;
        logic [DIV_W-1:0]                   span_03;
        logic [DIV_W-1:0]                   span_12;
        logic [DIV_W-1:0]                   span_13;
        logic [DIV_W-1:0]                   span_23;
        logic [MAX_LAYERS-1:0][END_W-1:0]   ends;
    } hmim_layout_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] dividend;
        logic [DIV_W-1:0]       divisor;
        logic [LAYER_W-1:0]     found;
        logic [ST_W-1:0]        status;
    } hmim_job_t;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_PROD,
        DRV_WIDE,
        DRV_TOTAL,
        DRV_END_LO,
        DRV_END_MID,
        DRV_END_HI
    } hmim_drv_state_t;

endpackage

/* sv/hmim_derive.sv */
// Configuration registers and the derived layer layout (spans and flat id bounds).
`timescale 1ns / 1ps

module hmim_derive
    import hmim_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  busy,
    output hmim_layout_t          layout
);

    hmim_drv_state_t state_reg, state_next;

    logic [LCNT_W-1:0]  lcount_reg;
    logic [SIZE_W-1:0]  size_reg [MAX_LAYERS];
    logic [LCNT_W-1:0]  used_layers;
    logic [SIZE_W-1:0]  es [MAX_LAYERS];

    logic load_prod, load_wide, load_total, load_end_lo, load_end_mid, load_end_hi;

    logic [DIV_W-1:0]   span01_reg, span12_reg, span23_reg;
    logic [PROD2_W-1:0] p02_reg, p13_reg, m2_reg;
    logic [DIV_W-1:0]   p03_reg, m1_reg;
    logic [K_W-1:0]     m0_reg;
    logic [MAX_LAYERS-1:0][END_W-1:0] ends_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcount_reg <= LCNT_W'(1);
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                size_reg[i] <= SIZE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAYER_COUNT: lcount_reg  <= cfg_data[LCNT_W-1:0];
                CFG_SIZE_0:      size_reg[0] <= cfg_data;
                CFG_SIZE_1:      size_reg[1] <= cfg_data;
                CFG_SIZE_2:      size_reg[2] <= cfg_data;
                CFG_SIZE_3:      size_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // effective sizes: zero reads as one, layers not in use count as one
    always_comb
    begin
        if (lcount_reg == '0)
            used_layers = LCNT_W'(1);
        else if (lcount_reg > LCNT_W'(MAX_LAYERS))
            used_layers = LCNT_W'(MAX_LAYERS);
        else
            used_layers = lcount_reg;
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            if (LCNT_W'(i) < used_layers && size_reg[i] != '0)
                es[i] = size_reg[i];
            else
                es[i] = SIZE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DRV_PROD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
            state_next = DRV_PROD;
        else
        begin
            case (state_reg)
                DRV_IDLE:    state_next = DRV_IDLE;
                DRV_PROD:    state_next = DRV_WIDE;
                DRV_WIDE:    state_next = DRV_TOTAL;
                DRV_TOTAL:   state_next = DRV_END_LO;
                DRV_END_LO:  state_next = DRV_END_MID;
                DRV_END_MID: state_next = DRV_END_HI;
                DRV_END_HI:  state_next = DRV_IDLE;
                default:     state_next = DRV_PROD;
            endcase
        end
    end

    always_comb
    begin
        busy         = 1'b1;
        load_prod    = 1'b0;
        load_wide    = 1'b0;
        load_total   = 1'b0;
        load_end_lo  = 1'b0;
        load_end_mid = 1'b0;
        load_end_hi  = 1'b0;
        case (state_reg)
            DRV_IDLE:    busy         = 1'b0;
            DRV_PROD:    load_prod    = 1'b1;
            DRV_WIDE:    load_wide    = 1'b1;
            DRV_TOTAL:   load_total   = 1'b1;
            DRV_END_LO:  load_end_lo  = 1'b1;
            DRV_END_MID: load_end_mid = 1'b1;
            DRV_END_HI:  load_end_hi  = 1'b1;
            default:     busy         = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            span01_reg <= DIV_W'(es[0]);
            span12_reg <= DIV_W'(es[1]);
            span23_reg <= DIV_W'(es[2]);
            p02_reg    <= PROD2_W'(es[0]) * PROD2_W'(es[1]);
            p13_reg    <= PROD2_W'(es[1]) * PROD2_W'(es[2]);
            m2_reg     <= PROD2_W'(es[2]) * PROD2_W'(es[3]);
        end
        if (load_wide)
        begin
            p03_reg <= DIV_W'(p02_reg) * DIV_W'(es[2]);
            m1_reg  <= DIV_W'(m2_reg) * DIV_W'(es[1]);
        end
        if (load_total)
            m0_reg <= K_W'(m1_reg) * K_W'(es[0]);
        if (load_end_lo)
        begin
            ends_reg[0] <= END_W'(m0_reg);
            ends_reg[1] <= END_W'(m0_reg) + END_W'(m1_reg);
        end
        if (load_end_mid)
            ends_reg[2] <= ends_reg[1] + END_W'(m2_reg);
        if (load_end_hi)
            ends_reg[3] <= ends_reg[2] + END_W'(es[3]);
    end

    always_comb
    begin
        layout.used_layers = used_layers;
        layout.span_01     = span01_reg;
        layout.span_02     = DIV_W'(p02_reg);
        layout.span_03     = p03_reg;
        layout.span_12     = span12_reg;
        layout.span_13     = DIV_W'(p13_reg);
        layout.span_23     = span23_reg;
        layout.ends        = ends_reg;
    end

endmodule

/* sv/hmim_front.sv */
// Front end: takes input items, checks layers, locates flat ids, picks dividend and divisor.
`timescale 1ns / 1ps

module hmim_front
    import hmim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 busy,
    input  hmim_layout_t         layout,
    input  logic                 q_full,
    output logic                 push,
    output hmim_job_t            push_job
);

    function automatic logic [DIV_W-1:0] span_of(hmim_layout_t lay, logic [LAYER_W-1:0] lo,
                                                 logic [LAYER_W-1:0] hi);
        logic [DIV_W-1:0] s;
        case ({lo, hi})
            4'b0001: s = lay.span_01;
            4'b0010: s = lay.span_02;
            4'b0011: s = lay.span_03;
            4'b0110: s = lay.span_12;
            4'b0111: s = lay.span_13;
            4'b1011: s = lay.span_23;
            default: s = DIV_W'(1);
        endcase
        return s;
    endfunction

    logic                   vld_reg, vld_next;
    hmim_job_t              job_reg;
    hmim_job_t              job_c;
    logic                   accept;

    logic [VALUE_WIDTH-1:0] val;
    logic [LAYER_W-1:0]     src;
    logic [TGT_W-1:0]       tgt;
    logic                   src_ok, tgt_ok;
    logic [END_W-1:0]       starts [MAX_LAYERS];
    logic [VALUE_WIDTH-1:0] locals [MAX_LAYERS];
    logic [MAX_LAYERS-1:0]  hits;
    logic [LAYER_W-1:0]     hit_idx;

    assign val = s_tdata[VALUE_WIDTH-1:0];
    assign src = s_tdata[VALUE_WIDTH+LAYER_W-1:VALUE_WIDTH];
    assign tgt = s_tdata[VALUE_WIDTH+LAYER_W+TGT_W-1:VALUE_WIDTH+LAYER_W];

    assign src_ok = {1'b0, src} < layout.used_layers;
    assign tgt_ok = tgt < layout.used_layers;

    // all layers checked in parallel, first hit wins
    always_comb
    begin
        starts[0] = '0;
        for (int l = 1; l < MAX_LAYERS; l++)
        begin
            starts[l] = layout.ends[l-1];
        end
        for (int l = 0; l < MAX_LAYERS; l++)
        begin
            hits[l]   = (LCNT_W'(l) < layout.used_layers) && ({1'b0, val} < layout.ends[l]);
            locals[l] = VALUE_WIDTH'({1'b0, val} - starts[l]);
        end
        hit_idx = '0;
        for (int l = MAX_LAYERS - 1; l >= 0; l--)
        begin
            if (hits[l])
                hit_idx = LAYER_W'(l);
        end
    end

    always_comb
    begin
        job_c.dividend = '0;
        job_c.divisor  = DIV_W'(1);
        job_c.found    = '0;
        job_c.status   = ST_OK;
        case (s_tuser)
            OP_BLOCK_TO_MODULE:
            begin
                if (!src_ok)
                    job_c.status = ST_LAYER_RANGE;
                else
                begin
                    job_c.dividend = val;
                    job_c.divisor  = span_of(layout, '0, src);
                end
            end
            OP_CONVERT:
            begin
                if (!src_ok || !tgt_ok)
                    job_c.status = ST_LAYER_RANGE;
                else if (tgt[LAYER_W-1:0] < src)
                    job_c.status = ST_TARGET_BELOW;
                else
                begin
                    job_c.dividend = val;
                    job_c.divisor  = span_of(layout, src, tgt[LAYER_W-1:0]);
                end
            end
            OP_MODULE_TO_FLAT:
            begin
                if (!src_ok)
                    job_c.status = ST_LAYER_RANGE;
                else
                    job_c.dividend = VALUE_WIDTH'({1'b0, val} + starts[src]);
            end
            default:
            begin
                if (!tgt_ok)
                    job_c.dividend = val;
                else if (hits == '0)
                    job_c.status = ST_PAST_LAST;
                else
                begin
                    job_c.found = hit_idx;
                    if (tgt[LAYER_W-1:0] < hit_idx)
                        job_c.status = ST_TARGET_BELOW;
                    else
                    begin
                        job_c.dividend = locals[hit_idx];
                        job_c.divisor  = span_of(layout, hit_idx, tgt[LAYER_W-1:0]);
                    end
                end
            end
        endcase
    end

    assign s_tready = !busy && (!vld_reg || !q_full);
    assign accept   = s_tvalid && s_tready;
    assign push     = vld_reg && !q_full;
    assign push_job = job_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (push)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_c;
    end

endmodule

/* sv/hmim_queue.sv */
// Short job queue between the front end and the divider pipeline.
`timescale 1ns / 1ps

module hmim_queue
    import hmim_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hmim_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      head_vld,
    output hmim_job_t head_job
);

    hmim_job_t         job_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_vld = count_reg != '0;
    assign head_job = job_reg[rd_ptr_reg];
    assign do_pop   = pop && head_vld;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            job_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* sv/hmim_div.sv */
// Back end: restoring divider, one quotient bit per stage, last stage is the output register.
`timescale 1ns / 1ps

module hmim_div
    import hmim_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_vld,
    input  hmim_job_t            head_job,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [ST_W-1:0]      m_tuser
);

    logic [VALUE_WIDTH-1:0] vld_reg, vld_next;
    logic [DIV_W-1:0]       rem_reg    [VALUE_WIDTH];
    logic [DIV_W-1:0]       rem_next   [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] num_reg    [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] num_next   [VALUE_WIDTH];
    logic [DIV_W-1:0]       dsr_reg    [VALUE_WIDTH];
    logic [DIV_W-1:0]       dsr_next   [VALUE_WIDTH];
    logic [LAYER_W-1:0]     found_reg  [VALUE_WIDTH];
    logic [LAYER_W-1:0]     found_next [VALUE_WIDTH];
    logic [ST_W-1:0]        status_reg [VALUE_WIDTH];
    logic [ST_W-1:0]        status_next[VALUE_WIDTH];
    logic [DIV_W-1:0]       rem_in     [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] num_in     [VALUE_WIDTH];
    logic [DIV_W:0]         trial      [VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0] ge;
    logic                   en;

    // whole pipeline moves together; it only holds when the output is stuck
    assign en  = m_tready || !vld_reg[DIV_LAST];
    assign pop = en && head_vld;

    always_comb
    begin
        for (int s = 0; s < VALUE_WIDTH; s++)
        begin
            if (s == 0)
            begin
                rem_in[s]      = '0;
                num_in[s]      = head_job.dividend;
                dsr_next[s]    = head_job.divisor;
                found_next[s]  = head_job.found;
                status_next[s] = head_job.status;
                vld_next[s]    = head_vld;
            end
            else
            begin
                rem_in[s]      = rem_reg[s-1];
                num_in[s]      = num_reg[s-1];
                dsr_next[s]    = dsr_reg[s-1];
                found_next[s]  = found_reg[s-1];
                status_next[s] = status_reg[s-1];
                vld_next[s]    = vld_reg[s-1];
            end
            trial[s] = {rem_in[s], num_in[s][VALUE_WIDTH-1]};
            ge[s]    = trial[s] >= {1'b0, dsr_next[s]};
            if (ge[s])
                rem_next[s] = DIV_W'(trial[s] - {1'b0, dsr_next[s]});
            else
                rem_next[s] = trial[s][DIV_W-1:0];
            num_next[s] = {num_in[s][VALUE_WIDTH-2:0], ge[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < VALUE_WIDTH; s++)
            begin
                rem_reg[s]    <= rem_next[s];
                num_reg[s]    <= num_next[s];
                dsr_reg[s]    <= dsr_next[s];
                found_reg[s]  <= found_next[s];
                status_reg[s] <= status_next[s];
            end
        end
    end

    assign m_tvalid = vld_reg[DIV_LAST];
    assign m_tdata  = {(M_TDATA_W - VALUE_WIDTH - LAYER_W)'(0), found_reg[DIV_LAST],
                       num_reg[DIV_LAST]};
    assign m_tuser  = status_reg[DIV_LAST];

endmodule

/* sv/hierarchy_module_index_mapper.sv */
// Top level of the hierarchy module index mapper.
`timescale 1ns / 1ps
//
// Maps block numbers, module numbers and flat ids between the layers of a
// hierarchy set up through the configuration channel (layer count, then one
// group size per layer). Each item on the s_ channel (s_tuser = operation)
// gives exactly one item on the m_ channel (m_tuser = status).
// A result passes through the front register, the job queue and the 33-stage
// divider pipeline, one quotient bit per stage, before it shows on m_tvalid.
// Throughput: one item per cycle while m_tready is high and no layout rebuild
// is under way; the divider takes a new job every cycle unless its output is
// stuck. After reset and after every configuration write, s_tready stays low
// while the multiplier chain rebuilds the layer spans and the flat id bounds.
// cfg_ready is always high; the user must make writes only while idle, and
// the block itself does not enforce this. When m_tready is low and a result
// waits on m_tvalid, the divider pipeline holds, the queue and front register
// fill up, and then s_tready drops; no item is lost or repeated. Reset
// (rst_n low) empties the pipeline, sets layer_count and all sizes to one.
//
module hierarchy_module_index_mapper
    import hmim_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // value, src layer, tgt layer, zero pad
    input  logic [OP_W-1:0]       s_tuser,    // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // result, found_layer, zero pad
    output logic [ST_W-1:0]       m_tuser,    // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    hmim_layout_t layout;
    hmim_job_t    push_job;
    hmim_job_t    head_job;
    logic         busy;
    logic         q_full;
    logic         push;
    logic         pop;
    logic         head_vld;

    assign cfg_ready = 1'b1;

    hmim_derive u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .layout    (layout)
    );

    hmim_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .busy     (busy),
        .layout   (layout),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    hmim_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_vld (head_vld),
        .head_job (head_job)
    );

    hmim_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_vld (head_vld),
        .head_job (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* sv/hmim_checker.sv */
// Port-level checks of the hierarchy module index mapper, bound to the top level.
`timescale 1ns / 1ps

module hmim_checker
    import hmim_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic [OP_W-1:0]       s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [ST_W-1:0]       m_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // any error status carries a zero result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[VALUE_WIDTH-1:0] == '0)
        else $error("nonzero result with error status");

    // found_layer is only reported once a layer was found
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_LAYER_RANGE || m_tuser == ST_PAST_LAST)
        |-> m_tdata[VALUE_WIDTH+LAYER_W-1:VALUE_WIDTH] == '0)
        else $error("found_layer set without a located layer");

    // layout rebuild after a write blocks new items
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("item accepted while layout is rebuilt");

endmodule

bind hierarchy_module_index_mapper hmim_checker u_checker (.*);
